/* design/qlsf_pkg.sv */
`timescale 1ns / 1ps
package qlsf_pkg;

  localparam int COORD_W    = 12;
  localparam int CNT_W      = 13;
  localparam int MAX_POINTS = 4096;
  localparam int FRAC_BITS  = 32;
  localparam int HSUM_W     = 60;
  localparam int RSUM_W     = 48;
  // operand slot width of a snapshot entry
  localparam int OPB_W      = 64;
  // signed width that holds every determinant exactly (terms stay below 2^120)
  localparam int DET_W      = 128;
  localparam int NUM_W      = DET_W + FRAC_BITS + 2;
  localparam int COEF_W     = 64;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int NSRC       = 8;

  typedef struct packed {
    logic [COORD_W-1:0] point_height;
    logic [COORD_W-1:0] point_radius;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_square;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_const;
    logic                     fit_ok;
  } out_item_t;

  typedef enum logic [2:0] {
    SRC_S0, SRC_S1, SRC_S2, SRC_S3, SRC_S4, SRC_R0, SRC_R1, SRC_R2
  } src_t;

  // frozen sums of one point set, indexed by src_t
  typedef struct packed {
    logic [NSRC-1:0][OPB_W-1:0] val;
  } snap_t;

  typedef struct packed {
    logic              ready;
    logic [QPTR_W:0]   level;
  } q_stat_t;

  // entry of the normal matrix, column det_sel-1 replaced by the radius sums
  function automatic src_t mat_src(input logic [1:0] det_sel, input logic [1:0] row,
                                   input logic [1:0] col);
    logic [2:0] s;
    if (det_sel != 2'd0 && col == det_sel - 2'd1) begin
      s = 3'(SRC_R0) + {1'b0, row};
    end else begin
      s = {1'b0, row} + {1'b0, col};
    end
    return src_t'(s);
  endfunction

  // column used by a row in each of the six terms of the 3x3 expansion
  function automatic logic [1:0] term_col(input logic [2:0] term, input logic [1:0] row);
    logic [5:0] p;
    unique case (term)
      3'd0:    p = {2'd0, 2'd1, 2'd2};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd2, 2'd0, 2'd1};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    unique case (row)
      2'd0:    return p[5:4];
      2'd1:    return p[3:2];
      default: return p[1:0];
    endcase
  endfunction

  function automatic logic term_neg(input logic [2:0] term);
    return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

endpackage

/* design/qlsf_front.sv */
`timescale 1ns / 1ps
module qlsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qlsf_pkg::in_item_t in_item,
  input  qlsf_pkg::q_stat_t q_stat,
  output logic              push,
  output qlsf_pkg::snap_t   push_data
);
  import qlsf_pkg::*;

  logic                 s1_v_r, s1_last_r;
  logic [COORD_W-1:0]   s1_h_r, s1_r_r;
  logic [2*COORD_W-1:0] s1_h2_r;
  logic                 s2_v_r, s2_last_r;
  logic [COORD_W-1:0]   s2_h_r, s2_r_r;
  logic [2*COORD_W-1:0] s2_h2_r, s2_rh_r;
  logic [3*COORD_W-1:0] s2_h3_r, s2_rh2_r;
  logic [4*COORD_W-1:0] s2_h4_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [HSUM_W-1:0]    hs_r [4];
  logic [RSUM_W-1:0]    rs_r [3];
  logic [HSUM_W-1:0]    hs_add [4];
  logic [RSUM_W-1:0]    rs_add [3];
  logic                 cnt_ok, accept;
  logic [2:0]           pending;

  // room must exist in the queue for every set end already in flight
  assign pending  = 3'(q_stat.level) + 3'(s1_v_r & s1_last_r) + 3'(s2_v_r & s2_last_r);
  assign in_stall = (pending >= 3'(QDEPTH)) || !q_stat.ready;
  assign accept   = in_valid && !in_stall;
  assign cnt_ok   = cnt_r < CNT_W'(MAX_POINTS);

  assign hs_add[0] = hs_r[0] + HSUM_W'(s2_h_r);
  assign hs_add[1] = hs_r[1] + HSUM_W'(s2_h2_r);
  assign hs_add[2] = hs_r[2] + HSUM_W'(s2_h3_r);
  assign hs_add[3] = hs_r[3] + HSUM_W'(s2_h4_r);
  assign rs_add[0] = rs_r[0] + RSUM_W'(s2_r_r);
  assign rs_add[1] = rs_r[1] + RSUM_W'(s2_rh_r);
  assign rs_add[2] = rs_r[2] + RSUM_W'(s2_rh2_r);

  assign push = s2_v_r && s2_last_r;
  always_comb begin
    push_data.val[SRC_S0] = OPB_W'(cnt_ok ? cnt_r + CNT_W'(1) : cnt_r);
    for (int i = 0; i < 4; i++) begin
      push_data.val[i+1] = OPB_W'(cnt_ok ? hs_add[i] : hs_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      push_data.val[i+5] = OPB_W'(cnt_ok ? rs_add[i] : rs_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    s1_h_r   <= in_item.point_height;
    s1_r_r   <= in_item.point_radius;
    s1_h2_r  <= in_item.point_height * in_item.point_height;
    s2_h_r   <= s1_h_r;
    s2_r_r   <= s1_r_r;
    s2_h2_r  <= s1_h2_r;
    s2_h3_r  <= s1_h2_r * s1_h_r;
    s2_h4_r  <= s1_h2_r * s1_h2_r;
    s2_rh_r  <= s1_r_r * s1_h_r;
    s2_rh2_r <= s1_r_r * s1_h2_r;
    s1_last_r <= in_item.last_point;
    s2_last_r <= s1_last_r;
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      cnt_r  <= '0;
      for (int i = 0; i < 4; i++) hs_r[i] <= '0;
      for (int i = 0; i < 3; i++) rs_r[i] <= '0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        if (s2_last_r) begin
          cnt_r <= '0;
          for (int i = 0; i < 4; i++) hs_r[i] <= '0;
          for (int i = 0; i < 3; i++) rs_r[i] <= '0;
        end else if (cnt_ok) begin
          cnt_r <= cnt_r + CNT_W'(1);
          for (int i = 0; i < 4; i++) hs_r[i] <= hs_add[i];
          for (int i = 0; i < 3; i++) rs_r[i] <= rs_add[i];
        end
      end
    end
  end

endmodule

/* design/qlsf_queue.sv */
`timescale 1ns / 1ps
module qlsf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qlsf_pkg::snap_t   push_data,
  input  logic              pop,
  output logic              not_empty,
  output qlsf_pkg::snap_t   head,
  output qlsf_pkg::q_stat_t q_stat
);
  import qlsf_pkg::*;

  snap_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign not_empty    = cnt_r != '0;
  assign head         = mem_r[rd_r];
  assign q_stat.level = cnt_r;
  assign q_stat.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

/* design/qlsf_back.sv */
`timescale 1ns / 1ps
module qlsf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  qlsf_pkg::snap_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output qlsf_pkg::out_item_t out_item
);
  import qlsf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD1, ST_LD2, ST_MUL1, ST_LD3, ST_MUL2, ST_ACC,
    ST_DET_END, ST_DIV, ST_DIV_END, ST_OUT
  } state_t;

  localparam logic signed [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  state_t                state_r;
  snap_t                 snap_r;
  logic [1:0]            det_sel_r;
  logic [2:0]            term_r;
  logic [DET_W-1:0]      a_r, prod_r;
  logic [OPB_W-1:0]      b_r;
  logic signed [DET_W-1:0] acc_r, det_r;
  logic [NUM_W-1:0]      dnum_r, q_r;
  logic [DET_W:0]        dden_r, rem_r;
  logic                  neg_r;
  logic [$clog2(NUM_W)-1:0] dcnt_r;
  logic signed [COEF_W-1:0] cf_r [3];
  logic                  ok_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic [1:0]            rd_row;
  src_t                  rd_src;
  logic [OPB_W-1:0]      rd_val;
  logic [DET_W-1:0]      mag_acc, mag_det;
  logic [DET_W+1:0]      rem2;
  logic                  qbit;
  logic signed [COEF_W-1:0] coef;
  logic                  out_free;

  always_comb begin
    unique case (state_r)
      ST_LD1:  rd_row = 2'd2;
      ST_LD2:  rd_row = 2'd1;
      default: rd_row = 2'd0;
    endcase
  end
  assign rd_src  = mat_src(det_sel_r, rd_row, term_col(term_r, rd_row));
  assign rd_val  = snap_r.val[rd_src];
  assign mag_acc = acc_r[DET_W-1] ? DET_W'(-acc_r) : DET_W'(acc_r);
  assign mag_det = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  assign rem2    = {rem_r, dnum_r[NUM_W-1]};
  assign qbit    = rem2 >= (DET_W+2)'(dden_r);

  // round-half-away quotient saturated to the coefficient range
  always_comb begin
    if (|q_r[NUM_W-1:COEF_W]) begin
      coef = neg_r ? SAT_MIN : SAT_MAX;
    end else if (!neg_r) begin
      coef = q_r[COEF_W-1] ? SAT_MAX : $signed(q_r[COEF_W-1:0]);
    end else if (q_r[COEF_W-1:0] > COEF_W'(SAT_MIN)) begin
      coef = SAT_MIN;
    end else begin
      coef = $signed(-q_r[COEF_W-1:0]);
    end
  end

  // result register is free when empty or being taken this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) out_valid_r <= (state_r == ST_OUT);
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            snap_r    <= q_head;
            det_sel_r <= 2'd0;
            term_r    <= 3'd0;
            acc_r     <= '0;
            state_r   <= ST_LD1;
          end
        end
        ST_LD1: begin
          a_r     <= DET_W'(rd_val);
          state_r <= ST_LD2;
        end
        ST_LD2: begin
          b_r     <= rd_val;
          prod_r  <= '0;
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          if (b_r == '0) begin
            state_r <= ST_LD3;
          end else begin
            if (b_r[0]) prod_r <= prod_r + a_r;
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end
        end
        ST_LD3: begin
          a_r     <= prod_r;
          b_r     <= rd_val;
          prod_r  <= '0;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          if (b_r == '0) begin
            state_r <= ST_ACC;
          end else begin
            if (b_r[0]) prod_r <= prod_r + a_r;
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end
        end
        ST_ACC: begin
          acc_r <= term_neg(term_r) ? acc_r - $signed(prod_r) : acc_r + $signed(prod_r);
          if (term_r == 3'd5) begin
            state_r <= ST_DET_END;
          end else begin
            term_r  <= term_r + 3'd1;
            state_r <= ST_LD1;
          end
        end
        ST_DET_END: begin
          term_r <= 3'd0;
          if (det_sel_r == 2'd0) begin
            det_r <= acc_r;
            acc_r <= '0;
            if (snap_r.val[SRC_S0] < OPB_W'(2) || acc_r == '0) begin
              for (int i = 0; i < 3; i++) cf_r[i] <= '0;
              ok_r    <= 1'b0;
              state_r <= ST_OUT;
            end else begin
              det_sel_r <= 2'd1;
              state_r   <= ST_LD1;
            end
          end else begin
            dnum_r  <= NUM_W'({mag_acc, {(FRAC_BITS+1){1'b0}}}) + NUM_W'(mag_det);
            dden_r  <= {mag_det, 1'b0};
            neg_r   <= acc_r[DET_W-1] ^ det_r[DET_W-1];
            rem_r   <= '0;
            q_r     <= '0;
            dcnt_r  <= ($clog2(NUM_W))'(NUM_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= qbit ? (DET_W+1)'(rem2 - (DET_W+2)'(dden_r)) : (DET_W+1)'(rem2);
          q_r    <= {q_r[NUM_W-2:0], qbit};
          dnum_r <= dnum_r << 1;
          if (dcnt_r == '0) begin
            state_r <= ST_DIV_END;
          end else begin
            dcnt_r <= dcnt_r - ($clog2(NUM_W))'(1);
          end
        end
        ST_DIV_END: begin
          cf_r[det_sel_r - 2'd1] <= coef;
          acc_r <= '0;
          if (det_sel_r == 2'd3) begin
            ok_r    <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            det_sel_r <= det_sel_r + 2'd1;
            state_r   <= ST_LD1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_item_r.coef_const  <= cf_r[0];
            out_item_r.coef_linear <= cf_r[1];
            out_item_r.coef_square <= cf_r[2];
            out_item_r.fit_ok      <= ok_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/quadratic_least_squares_fit.sv */
`timescale 1ns / 1ps
// solving: once its last point is taken, a set end passes the front's s1 and s2 registers
// into the queue; the back then forms four determinants of six terms, each term two
// shift-add products (48 serial products), then runs three 162-step restoring divisions;
// a singular or too short set ends after the first determinant
// throughput: one point per cycle; input stalls while two set ends are queued or in flight
// reset: synchronous active-low rst_n clears sums, queue pointers, solver state and out_valid
module quadratic_least_squares_fit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qlsf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output qlsf_pkg::out_item_t out_item
);
  import qlsf_pkg::*;

  // front: squares and higher powers in two register stages, then exact running sums
  // queue: frozen sums of completed sets, so the front keeps taking points while solving
  // back: Cramer's rule on the 3x3 normal matrix through one serial multiplier,
  //       then a rounded, saturated Q32.32 quotient for each coefficient
  logic    push, pop, not_empty;
  snap_t   push_data, head;
  q_stat_t q_stat;

  qlsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  qlsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .q_stat    (q_stat)
  );

  qlsf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

/* design/qlsf_checker.sv */
`timescale 1ns / 1ps
module qlsf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input qlsf_pkg::out_item_t out_item
);
  import qlsf_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a failed fit carries zero coefficients
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.fit_ok |->
      out_item.coef_square == '0 && out_item.coef_linear == '0 && out_item.coef_const == '0)
    else $error("failed fit with non-zero coefficients");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind quadratic_least_squares_fit qlsf_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

/* bench/qlsf_fit_checker.sv */
`timescale 1ns / 1ps
module qlsf_fit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  qlsf_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  qlsf_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  fits_pending
);
  import qlsf_pkg::*;

  typedef logic signed [255:0] wide_t;

  int          n_pts;
  logic [63:0] hpow_sum [4];
  logic [63:0] rad_sum [3];
  out_item_t   fit_queue [$];

  function automatic wide_t det3(input wide_t m [9]);
    return m[0] * (m[4] * m[8] - m[5] * m[7])
         - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
  endfunction

  // round(num / den * 2^FRAC_BITS), ties away from zero, saturated to 64 bits
  function automatic logic [63:0] q32_ratio(input wide_t num, input wide_t den);
    logic  neg;
    wide_t n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = (n <<< (FRAC_BITS + 1)) + d;
    q = n / (d <<< 1);
    if (!neg) return (q > wide_t'(64'h7FFF_FFFF_FFFF_FFFF)) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
    if (q >= wide_t'(64'h8000_0000_0000_0000)) return 64'h8000_0000_0000_0000;
    return -q[63:0];
  endfunction

  function automatic out_item_t solve_fit();
    out_item_t res;
    wide_t     s [5];
    wide_t     m [9];
    wide_t     d;
    wide_t     dk [3];
    s[0] = n_pts;
    for (int i = 0; i < 4; i++) s[i+1] = hpow_sum[i];
    for (int i = 0; i < 9; i++) m[i] = s[i/3 + i%3];
    d = det3(m);
    res = '0;
    if (n_pts >= 2 && d != 0) begin
      // replace column k (c, b, a order) by the radius sums
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 9; i++) m[i] = s[i/3 + i%3];
        for (int i = 0; i < 3; i++) m[i*3 + k] = rad_sum[i];
        dk[k] = det3(m);
      end
      res.coef_const  = q32_ratio(dk[0], d);
      res.coef_linear = q32_ratio(dk[1], d);
      res.coef_square = q32_ratio(dk[2], d);
      res.fit_ok      = 1'b1;
    end
    return res;
  endfunction

  task automatic clear_sums();
    n_pts = 0;
    for (int i = 0; i < 4; i++) hpow_sum[i] = '0;
    for (int i = 0; i < 3; i++) rad_sum[i] = '0;
  endtask

  initial begin
    fail_count = 0;
    clear_sums();
  end

  assign fits_pending = fit_queue.size();

  always @(posedge clk) begin
    logic [63:0] h, r, hp;
    out_item_t   want;
    if (rst_n && in_valid && !in_stall) begin
      h = in_item.point_height;
      r = in_item.point_radius;
      if (n_pts < MAX_POINTS) begin
        hp = 1;
        for (int i = 0; i < 4; i++) begin
          hp = hp * h;
          hpow_sum[i] += hp;
        end
        hp = 1;
        for (int i = 0; i < 3; i++) begin
          rad_sum[i] += r * hp;
          hp = hp * h;
        end
        n_pts++;
      end
      if (in_item.last_point) begin
        fit_queue.push_back(solve_fit());
        clear_sums();
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (fit_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected fit result %p", out_item);
      end else begin
        want = fit_queue.pop_front();
        if (want.coef_square !== out_item.coef_square ||
            want.coef_linear !== out_item.coef_linear ||
            want.coef_const !== out_item.coef_const || want.fit_ok !== out_item.fit_ok) begin
          fail_count++;
          if (fail_count <= 10)
            $display("fit mismatch: expected a=%h b=%h c=%h ok=%b got a=%h b=%h c=%h ok=%b",
                     want.coef_square, want.coef_linear, want.coef_const, want.fit_ok,
                     out_item.coef_square, out_item.coef_linear, out_item.coef_const,
                     out_item.fit_ok);
        end
      end
    end
  end
endmodule

/* bench/tb_quadratic_least_squares_fit.sv */
`timescale 1ns / 1ps
module tb_quadratic_least_squares_fit;
  import qlsf_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_item;
  int        fail_count;
  int        fits_pending;
  int        points_sent;
  int        cycle_count = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  logic      idle_on;

  quadratic_least_squares_fit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  qlsf_fit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .fits_pending(fits_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // burst window with no idling on either side
  assign idle_on = !(points_sent >= 100 && points_sent < 220);

  // watchdog: ends the run as failed once cycle_count reaches a limit far beyond any sane run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= 3000000) begin
      $display("quadratic_least_squares_fit verification failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold so that finished sets pile up
  always @(negedge clk) begin
    if (!hold_done && points_sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 12000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 28);
    end
  end

  // one point request, held until the block takes it
  task automatic send_point(input int h, input int r, input logic last);
    if (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid                <= 1'b1;
    in_item.point_height    <= COORD_W'(h);
    in_item.point_radius    <= COORD_W'(r);
    in_item.last_point      <= last;
    do @(posedge clk); while (in_stall);
    points_sent++;
    @(negedge clk);
  endtask

  // random set: general, singular, near-singular or tiny
  task automatic send_random_set();
    int kind, n, base, h;
    kind = $urandom_range(9);
    n    = $urandom_range(3, 12);
    base = $urandom_range(4093);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0:       h = $urandom_range(4095);
        1:       h = base;                          // one height only: singular
        2:       h = base + $urandom_range(2);      // crowded heights: huge coefficients
        3:       h = (i % 2) ? 4095 : 0;            // two heights only: singular
        default: h = $urandom_range(4095);
      endcase
      if (kind == 0 && i == 0) begin
        send_point(h, $urandom_range(4095), 1'b1); // one-point set
        return;
      end
      send_point(h, $urandom_range(4095), i == n - 1);
    end
  endtask

  initial begin
    in_valid    = 1'b0;
    in_item     = '0;
    rst_n       = 1'b0;
    points_sent = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: too few points, singular sets, extremes, exact parabola
    send_point(4095, 4095, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(4095, 4095, 1'b1);
    send_point(7, 100, 1'b0);
    send_point(7, 200, 1'b0);
    send_point(7, 300, 1'b1);
    send_point(0, 4095, 1'b0);
    send_point(2048, 0, 1'b0);
    send_point(4095, 4095, 1'b1);
    send_point(1, 6, 1'b0);       // r = h^2 + 2h + 3
    send_point(2, 11, 1'b0);
    send_point(3, 18, 1'b0);
    send_point(10, 123, 1'b1);
    send_point(4094, 0, 1'b0);
    send_point(4095, 4095, 1'b0);
    send_point(4093, 0, 1'b1);
    send_point(0, 4095, 1'b0);
    send_point(1, 0, 1'b0);
    send_point(2, 4095, 1'b1);

    // random sets
    while (points_sent < 500) begin
      send_random_set();
    end
    in_valid <= 1'b0;

    wait (fits_pending == 0);
    repeat (4000) @(posedge clk);
    if (fail_count == 0) begin
      $display("quadratic_least_squares_fit verification clean");
    end else begin
      $display("quadratic_least_squares_fit verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
design/qlsf_pkg.sv
design/qlsf_front.sv
design/qlsf_queue.sv
design/qlsf_back.sv
design/quadratic_least_squares_fit.sv
design/qlsf_checker.sv
bench/qlsf_fit_checker.sv
bench/tb_quadratic_least_squares_fit.sv
